### sv/stup_pkg.sv
// stup_pkg: shared widths, character codes, status codes and the digit decoder
// for the string to unsigned parser. No dependencies.
package stup_pkg;

  // fixed field widths
  localparam int CHAR_W   = 8;
  localparam int BASE_W   = 6;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int END_W    = 12;

  // default string length limit
  localparam int MAX_CHARS_DEFAULT = 4095;

  // radix limits and defaults
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_BAD   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_CONV  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_BASE = 2'd3
  } status_t;

  // decoded digit: ok is low for anything that is not 0-9, A-Z or a-z
  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } digit_t;

  function automatic digit_t char_digit(input logic [CHAR_W-1:0] c);
    digit_t d;
    logic [CHAR_W-1:0] diff;
    d = '0;
    diff = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff = c - CH_ZERO;
      d.ok = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      diff = c - CH_UP_A + 8'd10;
      d.ok = 1'b1;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      diff = c - CH_LO_A + 8'd10;
      d.ok = 1'b1;
    end
    d.val = diff[BASE_W-1:0];
    return d;
  endfunction

endpackage

### sv/string_to_unsigned_parser_top.sv
// string_to_unsigned_parser_top: character-serial string to 64-bit unsigned converter.
// Depends on stup_pkg for widths, codes and the digit decoder.

// The block takes one character per cycle and returns one result (value,
// status, end_offset) per beat marked last_char, held in the result register.
// A beat is first held in an input register, then goes through the parse
// step (whitespace, sign, 0x or octal prefix, one multiply-add of the 64-bit
// accumulator by the radix with a carry-out check for overflow) and the
// string state is updated. The accumulator feedback through that
// multiply-add sets the rate of one character per cycle. The result register
// lets non-final characters of the next string flow in while a result waits;
// only a last beat waits for the result register to free up. number_base is
// sampled at the first character of each string and should be written while
// the block is idle.
module string_to_unsigned_parser_top #(
  parameter int MAX_CHARS = stup_pkg::MAX_CHARS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          number_base_write,
  input  logic [stup_pkg::BASE_W-1:0]   number_base,
  // character channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stup_pkg::CHAR_W-1:0]   char_code,
  input  logic                          last_char,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stup_pkg::VALUE_W-1:0]  value,
  output logic [stup_pkg::STATUS_W-1:0] status,
  output logic [stup_pkg::END_W-1:0]    end_offset
);

  import stup_pkg::*;

  localparam int POS_W = $clog2(MAX_CHARS + 1);
  localparam int EXT_W = (POS_W > END_W) ? POS_W : END_W;
  localparam int MAC_W = VALUE_W + BASE_W + 1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHARS);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // configuration register
  logic [BASE_W-1:0] base_reg;

  // input register
  logic              in_full;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  // string state
  phase_t             parse_phase, parse_phase_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic               negative_flag, negative_flag_next;
  logic               overflow_flag, overflow_flag_next;
  logic [BASE_W-1:0]  active_base, active_base_next;
  logic [POS_W-1:0]   char_position, char_position_next;
  logic [POS_W-1:0]   digits_start, digits_start_next;
  logic [POS_W-1:0]   stop_position, stop_position_next;
  logic               prefix_skipped, prefix_skipped_next;

  // result register
  logic               out_full;
  logic [VALUE_W-1:0] out_raw, out_raw_next;
  logic               out_neg, out_neg_next;
  status_t            out_status, out_status_next;
  logic [END_W-1:0]   out_end, out_end_next;

  // handshake
  logic advance;
  logic in_accept;

  assign advance   = in_full && (!in_last || !out_full || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  // parse step datapath
  digit_t           dig;
  logic             term;
  logic             is_space;
  logic             start;
  logic             feed;
  logic [BASE_W-1:0] feed_base;
  logic [MAC_W-1:0] mac;
  logic             mac_ovf;
  logic             base_bad;

  assign dig      = char_digit(in_char);
  assign term     = (in_char == CH_NUL) || (char_position >= POS_LIMIT);
  assign is_space = (in_char == CH_SPACE) || (in_char >= CH_TAB && in_char <= CH_CR);

  // one multiply-add per character; carry-out past 64 bits is overflow
  assign mac     = MAC_W'(accumulator) * MAC_W'(feed_base) + MAC_W'(dig.val);
  assign mac_ovf = |mac[MAC_W-1:VALUE_W];

  always_comb begin
    logic [BASE_W-1:0] ab;
    phase_t            ph;
    logic [EXT_W-1:0]  end_ext;

    parse_phase_next    = parse_phase;
    accumulator_next    = accumulator;
    negative_flag_next  = negative_flag;
    overflow_flag_next  = overflow_flag;
    active_base_next    = active_base;
    char_position_next  = char_position;
    digits_start_next   = digits_start;
    stop_position_next  = stop_position;
    prefix_skipped_next = prefix_skipped;
    out_raw_next        = '0;
    out_neg_next        = 1'b0;
    out_status_next     = ST_OK;
    out_end_next        = '0;
    start               = 1'b0;
    feed                = 1'b0;
    feed_base           = '0;
    base_bad            = 1'b0;
    end_ext             = '0;

    // sample the radix at the first character
    ab = active_base;
    ph = parse_phase;
    if (char_position == '0) begin
      ab = base_reg;
      if (base_reg == BASE_BAD || base_reg > BASE_MAX) begin
        ph = PH_DONE;
      end
    end
    parse_phase_next = ph;
    active_base_next = ab;

    // phase handling ahead of the digit step
    unique case (ph)
      PH_SPACE: begin
        if (!term && is_space) begin
          parse_phase_next = PH_SPACE;
        end else if (!term && in_char == CH_MINUS) begin
          negative_flag_next = 1'b1;
          parse_phase_next   = PH_SIGN;
        end else if (!term && in_char == CH_PLUS) begin
          parse_phase_next = PH_SIGN;
        end else begin
          start = 1'b1;
        end
      end
      PH_SIGN: begin
        start = 1'b1;
      end
      PH_ZERO: begin
        if (!term && (in_char == CH_LO_X || in_char == CH_UP_X)) begin
          active_base_next    = BASE_HEX;
          prefix_skipped_next = 1'b1;
          digits_start_next   = char_position + 1'b1;
          stop_position_next  = char_position + 1'b1;
          parse_phase_next    = PH_DIGITS;
        end else begin
          if (ab == BASE_AUTO) begin
            active_base_next = BASE_OCT;
          end
          accumulator_next = '0;
          feed             = 1'b1;
        end
      end
      PH_DIGITS: begin
        feed = 1'b1;
      end
      PH_DONE: begin
        parse_phase_next = PH_DONE;
      end
      default: begin
        parse_phase_next = PH_DONE;
      end
    endcase

    // first character of the number proper
    if (start) begin
      digits_start_next  = char_position;
      stop_position_next = char_position;
      if (!term && in_char == CH_ZERO && (ab == BASE_AUTO || ab == BASE_HEX)) begin
        parse_phase_next = PH_ZERO;
      end else begin
        if (ab == BASE_AUTO) begin
          active_base_next = BASE_DEC;
        end
        feed = 1'b1;
      end
    end

    // digit step
    feed_base = active_base_next;
    if (feed) begin
      if (term || feed_base < 6'd2 || !dig.ok || dig.val >= feed_base) begin
        parse_phase_next   = PH_DONE;
        stop_position_next = char_position;
      end else begin
        if (mac_ovf) begin
          overflow_flag_next = 1'b1;
        end else begin
          accumulator_next = mac[VALUE_W-1:0];
        end
        stop_position_next = char_position + 1'b1;
        parse_phase_next   = PH_DIGITS;
      end
    end

    // position counter saturates at the limit
    if (char_position < POS_LIMIT) begin
      char_position_next = char_position + 1'b1;
    end

    // result at the last character
    base_bad = (active_base_next == BASE_BAD) || (active_base_next > BASE_MAX);
    if (base_bad) begin
      out_status_next = ST_BAD_BASE;
    end else begin
      if (parse_phase_next == PH_ZERO) begin
        accumulator_next   = '0;
        stop_position_next = digits_start_next + 1'b1;
      end else if (parse_phase_next == PH_SPACE || parse_phase_next == PH_SIGN) begin
        digits_start_next   = '0;
        stop_position_next  = '0;
        prefix_skipped_next = 1'b0;
      end
      if (stop_position_next == digits_start_next) begin
        out_status_next = ST_NO_CONV;
        if (prefix_skipped_next && digits_start_next != '0) begin
          end_ext = EXT_W'(digits_start_next - 1'b1);
        end
      end else if (overflow_flag_next) begin
        out_status_next = ST_OVERFLOW;
        out_raw_next    = '1;
        end_ext         = EXT_W'(stop_position_next);
      end else begin
        out_status_next = ST_OK;
        out_raw_next    = accumulator_next;
        out_neg_next    = negative_flag_next;
        end_ext         = EXT_W'(stop_position_next);
      end
    end
    out_end_next = end_ext[END_W-1:0];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= BASE_RESET;
    end else if (number_base_write) begin
      base_reg <= number_base;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_accept) begin
      in_char <= char_code;
      in_last <= last_char;
    end
  end

  // string state, cleared after each last beat
  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      parse_phase    <= PH_SPACE;
      accumulator    <= '0;
      negative_flag  <= 1'b0;
      overflow_flag  <= 1'b0;
      active_base    <= '0;
      char_position  <= '0;
      digits_start   <= '0;
      stop_position  <= '0;
      prefix_skipped <= 1'b0;
    end else if (advance) begin
      parse_phase    <= parse_phase_next;
      accumulator    <= accumulator_next;
      negative_flag  <= negative_flag_next;
      overflow_flag  <= overflow_flag_next;
      active_base    <= active_base_next;
      char_position  <= char_position_next;
      digits_start   <= digits_start_next;
      stop_position  <= stop_position_next;
      prefix_skipped <= prefix_skipped_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance && in_last) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
    if (advance && in_last) begin
      out_raw    <= out_raw_next;
      out_neg    <= out_neg_next;
      out_status <= out_status_next;
      out_end    <= out_end_next;
    end
  end

  // negation after a minus sign is applied on the way out
  assign out_valid  = out_full;
  assign value      = out_neg ? (VALUE_W'(0) - out_raw) : out_raw;
  assign status     = out_status;
  assign end_offset = out_end;

endmodule
